>>> design/soc_pkg.sv
package soc_pkg;

  // sizes of the record store and the arithmetic
  localparam int MAX_RECORDS = 64;
  localparam int LENGTH_BITS = 16;
  localparam int REF_BITS    = 16;
  localparam int POS_BITS    = 31;
  localparam int ADDR_W      = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int REC_W       = LENGTH_BITS + REF_BITS + POS_BITS;
  localparam int SQ_W        = 2 * LENGTH_BITS;
  localparam int ACC_W       = SQ_W + CNT_W;
  localparam int REM_W       = CNT_W - 1 > 0 ? CNT_W - 1 : 1;

  // sequencing lengths
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = LENGTH_BITS;
  localparam int DRAIN      = 3;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // result kinds
  localparam logic [1:0] KIND_DEL  = 2'd0;
  localparam logic [1:0] KIND_INS  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rewind;
    logic acc_clr;
    logic issue;
    logic pass_var;
    logic pass_cls;
    logic div_load;
    logic div_step;
    logic mean_latch;
    logic sqrt_init;
    logic sqrt_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_done;
  } status_t;

endpackage

>>> design/soc_ram.sv
module soc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/soc_datapath.sv
module soc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  soc_pkg::cmd_t                      cmd_i,
  output soc_pkg::status_t                   status_o,
  input  logic [soc_pkg::LENGTH_BITS-1:0]    read_length_i,
  input  logic signed [soc_pkg::REF_BITS-1:0] ref_id_i,
  input  logic [soc_pkg::POS_BITS-1:0]       position_i,
  output logic                               result_valid_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]    out_length_o,
  output logic signed [soc_pkg::REF_BITS-1:0] out_ref_id_o,
  output logic [soc_pkg::POS_BITS-1:0]       out_position_o,
  output logic [1:0]                         kind_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]    mean_length_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]    deviation_o,
  output logic                               overflowed_o,
  output logic                               last_result_o
);
  import soc_pkg::*;

  logic [CNT_W-1:0]       count_q, rd_addr_q;
  logic                   ovf_q, rd_v_q, sq_v_q;
  logic [REC_W-1:0]       rdata;
  logic [LENGTH_BITS-1:0] v, mean_q, d;
  logic [SQ_W-1:0]        sq_q;
  logic [ACC_W-1:0]       acc_q, dvd_q;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [REM_W:0]         trial;
  logic                   ge;
  logic [SQ_W-1:0]        x_q, r_q, bit_q, rb;
  logic                   sq_ge;
  logic                   room, del, ins, flag;
  logic [LENGTH_BITS:0]   hi_bound;
  logic [LENGTH_BITS-1:0] dev;

  // pending flagged record, held back to mark the final one
  logic                   pend_v_q;
  logic [LENGTH_BITS-1:0] pend_len_q;
  logic [REF_BITS-1:0]    pend_ref_q;
  logic [POS_BITS-1:0]    pend_pos_q;
  logic [1:0]             pend_kind_q;

  logic                   out_v_q, out_last_q, out_ovf_q;
  logic [LENGTH_BITS-1:0] out_len_q, out_mean_q, out_dev_q;
  logic [REF_BITS-1:0]    out_ref_q;
  logic [POS_BITS-1:0]    out_pos_q;
  logic [1:0]             out_kind_q;

  assign room = count_q < CNT_W'(MAX_RECORDS);

  soc_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && room),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({read_length_i, ref_id_i, position_i}),
    .re_i    (cmd_i.issue),
    .raddr_i (rd_addr_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign status_o.issue_done = (rd_addr_q == count_q);

  assign v   = rdata[REC_W-1 -: LENGTH_BITS];
  assign d   = (v >= mean_q) ? (v - mean_q) : (mean_q - v);
  assign dev = r_q[LENGTH_BITS-1:0];

  // divider step: restoring, one quotient bit a cycle
  assign trial = {rem_q, dvd_q[ACC_W-1]};
  assign ge    = ({1'b0, trial} >= {1'b0, count_q});
  assign rem_d = ge ? REM_W'(trial - (REM_W+1)'(count_q)) : trial[REM_W-1:0];

  // square root step
  assign rb    = r_q + bit_q;
  assign sq_ge = x_q >= rb;

  // classification against the one-sigma band
  assign hi_bound = {1'b0, mean_q} + {1'b0, dev};
  assign del  = (dev <= mean_q) && (v < (mean_q - dev));
  assign ins  = !del && ({1'b0, v} > hi_bound);
  assign flag = cmd_i.pass_cls && rd_v_q && (del || ins);

  // store fill and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (room) begin
        count_q <= count_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // read address and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_v_q    <= 1'b0;
      sq_v_q    <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.issue;
      sq_v_q <= rd_v_q && cmd_i.pass_var;
      if (cmd_i.rewind) begin
        rd_addr_q <= '0;
      end else if (cmd_i.issue) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
    end
  end

  // square of the distance, registered before accumulation
  always_ff @(posedge clk_i) begin
    sq_q <= d * d;
  end

  // accumulator for the sum and the sum of squared distances from the mean
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (sq_v_q) begin
      acc_q <= acc_q + ACC_W'(sq_q);
    end else if (rd_v_q && !cmd_i.pass_var && !cmd_i.pass_cls) begin
      acc_q <= acc_q + ACC_W'(v);
    end
  end

  // divider and mean
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= acc_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[ACC_W-2:0], ge};
      rem_q <= rem_d;
    end
    if (cmd_i.mean_latch) begin
      mean_q <= dvd_q[LENGTH_BITS-1:0];
    end
  end

  // square root, two radicand bits a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      x_q   <= dvd_q[SQ_W-1:0];
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // pending item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.finish) begin
      pend_v_q <= 1'b0;
    end else if (flag) begin
      pend_v_q <= 1'b1;
    end
  end

  // pending item payload
  always_ff @(posedge clk_i) begin
    if (flag) begin
      pend_len_q  <= v;
      pend_ref_q  <= rdata[POS_BITS +: REF_BITS];
      pend_pos_q  <= rdata[POS_BITS-1:0];
      pend_kind_q <= del ? KIND_DEL : KIND_INS;
    end
  end

  // output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cmd_i.finish || (flag && pend_v_q);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish || (flag && pend_v_q)) begin
      out_mean_q <= mean_q;
      out_dev_q  <= dev;
      out_ovf_q  <= ovf_q;
      out_last_q <= cmd_i.finish;
      if (pend_v_q) begin
        out_len_q  <= pend_len_q;
        out_ref_q  <= pend_ref_q;
        out_pos_q  <= pend_pos_q;
        out_kind_q <= pend_kind_q;
      end else begin
        out_len_q  <= '0;
        out_ref_q  <= '0;
        out_pos_q  <= '0;
        out_kind_q <= KIND_NONE;
      end
    end
  end

  assign result_valid_o = out_v_q;
  assign out_length_o   = out_len_q;
  assign out_ref_id_o   = out_ref_q;
  assign out_position_o = out_pos_q;
  assign kind_o         = out_kind_q;
  assign mean_length_o  = out_mean_q;
  assign deviation_o    = out_dev_q;
  assign overflowed_o   = out_ovf_q;
  assign last_result_o  = out_last_q;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> !status_o.issue_done)
    else $error("read issued past the stored records");

  a_finish_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (count_q == '0) && !pend_v_q && out_v_q && out_last_q)
    else $error("run did not close cleanly");

endmodule

>>> design/soc_ctrl.sv
module soc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_record_i,
  input  soc_pkg::status_t status_i,
  output soc_pkg::cmd_t    cmd_o,
  output logic             busy_o
);
  import soc_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIVM = 3'd2;
  localparam logic [2:0] S_VAR  = 3'd3;
  localparam logic [2:0] S_DIVV = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_CLS  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              accept;

  assign busy_o = (state_q != S_LOAD);
  assign accept = start_i && !busy_o;

  // sequencing of the passes
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = accept;
        if (accept && last_record_i) begin
          cmd_o.rewind  = 1'b1;
          cmd_o.acc_clr = 1'b1;
          cnt_d         = '0;
          state_d       = S_SUM;
        end
      end
      S_SUM, S_VAR, S_CLS: begin
        cmd_o.pass_var = (state_q == S_VAR);
        cmd_o.pass_cls = (state_q == S_CLS);
        if (!status_i.issue_done) begin
          cmd_o.issue = 1'b1;
        end else if (cnt_q == STEP_W'(DRAIN - 1)) begin
          cnt_d = '0;
          if (state_q == S_CLS) begin
            cmd_o.finish = 1'b1;
            state_d      = S_LOAD;
          end else begin
            cmd_o.div_load = 1'b1;
            state_d        = (state_q == S_SUM) ? S_DIVM : S_DIVV;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIVM, S_DIVV: begin
        if (cnt_q == STEP_W'(DIV_STEPS)) begin
          cnt_d = '0;
          if (state_q == S_DIVM) begin
            cmd_o.mean_latch = 1'b1;
            cmd_o.rewind     = 1'b1;
            cmd_o.acc_clr    = 1'b1;
            state_d          = S_VAR;
          end else begin
            cmd_o.sqrt_init = 1'b1;
            state_d         = S_SQRT;
          end
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
          cnt_d        = '0;
          cmd_o.rewind = 1'b1;
          state_d      = S_CLS;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_LOAD;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // checks
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_LOAD))
    else $error("record stored while busy");

  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> (cnt_q < STEP_W'(DIV_STEPS)))
    else $error("divider over-run");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !busy_o)
    else $error("block still busy after the run");

endmodule

>>> design/sigma_outlier_classifier.sv
// records load at one per cycle while busy_o is low; a non-final record gives no result
// after the final record, with n stored records, the run goes through these steps in order:
// sum pass, divide, square pass, divide, square root, classify pass
// the store's single read port sets the pass lengths, the bit-serial divider and square root the rest
// results come at most one per cycle, the last one in the first cycle with busy_o low
// asynchronous active-low reset clears control state; the store holds no reset value
module sigma_outlier_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [soc_pkg::LENGTH_BITS-1:0]     read_length_i,
  input  logic signed [soc_pkg::REF_BITS-1:0] ref_id_i,
  input  logic [soc_pkg::POS_BITS-1:0]        position_i,
  input  logic                                last_record_i,
  output logic                                result_valid_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]     out_length_o,
  output logic signed [soc_pkg::REF_BITS-1:0] out_ref_id_o,
  output logic [soc_pkg::POS_BITS-1:0]        out_position_o,
  output logic [1:0]                          kind_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]     mean_length_o,
  output logic [soc_pkg::LENGTH_BITS-1:0]     deviation_o,
  output logic                                overflowed_o,
  output logic                                last_result_o
);
  import soc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  soc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .last_record_i (last_record_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .busy_o        (busy_o)
  );

  // store, arithmetic and result register
  soc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .read_length_i  (read_length_i),
    .ref_id_i       (ref_id_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .out_length_o   (out_length_o),
    .out_ref_id_o   (out_ref_id_o),
    .out_position_o (out_position_o),
    .kind_o         (kind_o),
    .mean_length_o  (mean_length_o),
    .deviation_o    (deviation_o),
    .overflowed_o   (overflowed_o),
    .last_result_o  (last_result_o)
  );

endmodule

>>> tb/sigma_outlier_checker.sv
`timescale 1ns / 1ps

module sigma_outlier_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [soc_pkg::LENGTH_BITS-1:0]     read_length_i,
  input  logic signed [soc_pkg::REF_BITS-1:0] ref_id_i,
  input  logic [soc_pkg::POS_BITS-1:0]        position_i,
  input  logic                                last_record_i,
  input  logic                                result_valid_i,
  input  logic [soc_pkg::LENGTH_BITS-1:0]     out_length_i,
  input  logic signed [soc_pkg::REF_BITS-1:0] out_ref_id_i,
  input  logic [soc_pkg::POS_BITS-1:0]        out_position_i,
  input  logic [1:0]                          kind_i,
  input  logic [soc_pkg::LENGTH_BITS-1:0]     mean_length_i,
  input  logic [soc_pkg::LENGTH_BITS-1:0]     deviation_i,
  input  logic                                overflowed_i,
  input  logic                                last_result_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import soc_pkg::*;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] len;
    logic [REF_BITS-1:0]    ref_id;
    logic [POS_BITS-1:0]    pos;
    logic [1:0]             kind;
    logic [LENGTH_BITS-1:0] mean;
    logic [LENGTH_BITS-1:0] dev;
    logic                   ovf;
    logic                   last;
  } flagged_t;

  flagged_t               flagged_q[$];
  logic [LENGTH_BITS-1:0] len_mem[MAX_RECORDS];
  logic [REF_BITS-1:0]    ref_mem[MAX_RECORDS];
  logic [POS_BITS-1:0]    pos_mem[MAX_RECORDS];
  int                     stored;
  logic                   dropped;
  int                     fails;

  assign fail_count_o = fails;
  assign pending_o    = flagged_q.size();

  // floored integer square root
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  // close the set: statistics, then flag records outside one sigma or queue a none result
  task automatic classify_set();
    longint unsigned sum, sq, mean, dev, d;
    flagged_t        f;
    int              hits;
    sum = 0;
    sq  = 0;
    mean = 0;
    dev = 0;
    hits = 0;
    if (stored > 0) begin
      for (int i = 0; i < stored; i++) sum += len_mem[i];
      mean = sum / stored;
      for (int i = 0; i < stored; i++) begin
        d = (len_mem[i] >= mean) ? len_mem[i] - mean : mean - len_mem[i];
        sq += d * d;
      end
      dev = floor_sqrt(sq / stored);
    end
    for (int i = 0; i < stored; i++) begin
      f = '0;
      f.len = len_mem[i];
      f.ref_id = ref_mem[i];
      f.pos = pos_mem[i];
      f.mean = mean[LENGTH_BITS-1:0];
      f.dev = dev[LENGTH_BITS-1:0];
      f.ovf = dropped;
      if (dev <= mean && len_mem[i] < mean - dev) begin
        f.kind = KIND_DEL;
        flagged_q = {flagged_q, f};
        hits++;
      end else if (len_mem[i] > mean + dev) begin
        f.kind = KIND_INS;
        flagged_q = {flagged_q, f};
        hits++;
      end
    end
    if (hits == 0) begin
      f = '0;
      f.kind = KIND_NONE;
      f.mean = mean[LENGTH_BITS-1:0];
      f.dev = dev[LENGTH_BITS-1:0];
      f.ovf = dropped;
      flagged_q = {flagged_q, f};
    end
    flagged_q[$].last = 1'b1;
    stored = 0;
    dropped = 1'b0;
  endtask

  // accepted item into the store
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored = 0;
      dropped = 1'b0;
    end else if (start_i && !busy_i) begin
      if (stored < MAX_RECORDS) begin
        len_mem[stored] = read_length_i;
        ref_mem[stored] = ref_id_i;
        pos_mem[stored] = position_i;
        stored++;
      end else begin
        dropped = 1'b1;
      end
      if (last_record_i) classify_set();
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    flagged_t got, want;
    if (rst_ni && result_valid_i) begin
      got = {out_length_i, out_ref_id_i, out_position_i, kind_i, mean_length_i,
             deviation_i, overflowed_i, last_result_i};
      if (flagged_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %p", got);
      end else begin
        want = flagged_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial fails = 0;

endmodule

>>> tb/sigma_outlier_classifier_tb.sv
`timescale 1ns / 1ps

module sigma_outlier_classifier_tb;
  import soc_pkg::*;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [LENGTH_BITS-1:0]      read_length;
  logic signed [REF_BITS-1:0]  ref_id;
  logic [POS_BITS-1:0]         position;
  logic                        last_record;
  logic                        result_valid;
  logic [LENGTH_BITS-1:0]      out_length;
  logic signed [REF_BITS-1:0]  out_ref_id;
  logic [POS_BITS-1:0]         out_position;
  logic [1:0]                  kind;
  logic [LENGTH_BITS-1:0]      mean_length;
  logic [LENGTH_BITS-1:0]      deviation;
  logic                        overflowed;
  logic                        last_result;
  int                          fail_count;
  int                          pending;
  int                          quiet_cycles;
  int                          sent;
  int                          burst_left;

  localparam int QUIET_LIMIT = 20000;

  sigma_outlier_classifier i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .read_length_i  (read_length),
    .ref_id_i       (ref_id),
    .position_i     (position),
    .last_record_i  (last_record),
    .result_valid_o (result_valid),
    .out_length_o   (out_length),
    .out_ref_id_o   (out_ref_id),
    .out_position_o (out_position),
    .kind_o         (kind),
    .mean_length_o  (mean_length),
    .deviation_o    (deviation),
    .overflowed_o   (overflowed),
    .last_result_o  (last_result)
  );

  sigma_outlier_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .read_length_i  (read_length),
    .ref_id_i       (ref_id),
    .position_i     (position),
    .last_record_i  (last_record),
    .result_valid_i (result_valid),
    .out_length_i   (out_length),
    .out_ref_id_i   (out_ref_id),
    .out_position_i (out_position),
    .kind_i         (kind),
    .mean_length_i  (mean_length),
    .deviation_i    (deviation),
    .overflowed_i   (overflowed),
    .last_result_i  (last_result),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on cycles with no item and no result
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // drive one item from a falling edge and hold it until accepted
  task automatic send_record(input logic [LENGTH_BITS-1:0] len,
                             input logic [REF_BITS-1:0] rid,
                             input logic [POS_BITS-1:0] pos,
                             input logic last);
    logic was_busy;
    // random gap between bursts
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    start       <= 1'b1;
    read_length <= len;
    ref_id      <= rid;
    position    <= pos;
    last_record <= last;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  // random reference index covering -1 and the full positive range
  function automatic logic [REF_BITS-1:0] pick_ref();
    return ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 32767));
  endfunction

  // one random set with a chosen shape of length spread
  task automatic send_random_set();
    int                     size, shape;
    logic [LENGTH_BITS-1:0] base, len;
    size  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    shape = $urandom_range(0, 3);
    base  = 16'($urandom);
    for (int i = 0; i < size; i++) begin
      case (shape)
        0: len = base;
        1: len = base + 16'($urandom_range(0, 40));
        2: len = 16'($urandom);
        default: begin
          len = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                            : base + 16'($urandom_range(0, 3));
        end
      endcase
      send_record(len, pick_ref(), 31'($urandom), i == size - 1);
    end
  endtask

  initial begin
    logic [LENGTH_BITS-1:0] lens[$];
    rst_n        = 1'b0;
    start        = 1'b0;
    read_length  = '0;
    ref_id       = '0;
    position     = '0;
    last_record  = 1'b0;
    quiet_cycles = 0;
    sent         = 0;
    burst_left   = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single record: no spread, a none result
    send_record(16'hffff, 16'sh7fff, 31'h7fffffff, 1'b1);
    // extremes of length with one insertion and no deletion
    send_record(16'd0, -16'sd1, 31'd0, 1'b0);
    send_record(16'd100, 16'sd5, 31'd12345, 1'b0);
    send_record(16'd100, 16'sd6, 31'd54321, 1'b0);
    send_record(16'hffff, 16'sh7fff, 31'h7fffffff, 1'b1);
    // deviation above mean: no deletions possible
    lens = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hffff};
    foreach (lens[i]) send_record(lens[i], 16'sd1, 31'(i), i == lens.size() - 1);
    // equal lengths: nothing flagged
    for (int i = 0; i < 4; i++) send_record(16'd777, -16'sd1, 31'h55555555, i == 3);
    // spread around a mean with both kinds
    lens = '{16'd10, 16'd50, 16'd50, 16'd50, 16'd90};
    foreach (lens[i]) send_record(lens[i], 16'sh2aaa, 31'h2aaaaaaa, i == lens.size() - 1);

    // random sets, with overflowing sets now and then
    while (sent < 500) send_random_set();

    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
